// ----- rtl/core/gtic_pkg.sv -----
// Shared constants and controller/datapath interface types for the gesture capture block.
package gtic_pkg;

  localparam int SAMPLE_W = 16;
  localparam int THR_W    = 15;
  localparam int MINC_W   = 16;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 16;

  localparam int HISTORY_DEPTH_DEF = 50;
  localparam int WINDOW_LEN_DEF    = 20;

  localparam logic [THR_W-1:0]  THR_RST   = THR_W'(1700);
  localparam logic [THR_W-1:0]  IDLE_RST  = THR_W'(100);
  localparam logic [MINC_W-1:0] MINC_RST  = MINC_W'(100);

  localparam logic [CFG_IW-1:0] CFG_TRIG_THRESHOLD = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_IDLE_LIMIT     = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_MIN_CAPTURE    = 2'd2;

  typedef struct packed {
    logic take;
    logic cnt_clr;
    logic hrd;
    logic wrd;
    logic acc_sum;
    logic acc_dev;
    logic div;
    logic mean;
    logic chk;
    logic cmp;
    logic load_hist;
    logic load_live;
  } cmd_t;

  typedef struct packed {
    logic capturing;
    logic trig;
    logic slot_free;
    logic test;
    logic hist_done;
    logic win_done;
    logic rd_vld;
  } sts_t;

endpackage

// ----- rtl/core/gtic_ctrl.sv -----
// Sequencer for history dump, window mean/deviation passes and result loading.
module gtic_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  gtic_pkg::sts_t  sts,
  output gtic_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_OBS, S_DRD, S_DPUT, S_CHK, S_SUM, S_DIV, S_MEAN, S_DEV, S_CMP, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = sts.capturing ? S_CHK : S_OBS;
        end
      end
      S_OBS: begin
        cmd.cnt_clr = 1'b1;
        state_nxt   = sts.trig ? S_DRD : S_IDLE;
      end
      S_DRD: begin
        cmd.hrd   = 1'b1;
        state_nxt = S_DPUT;
      end
      S_DPUT: begin
        if (sts.slot_free) begin
          cmd.load_hist = 1'b1;
          if (sts.hist_done) state_nxt = S_IDLE;
          else cmd.hrd = 1'b1;
        end
      end
      S_CHK: begin
        cmd.chk     = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt   = sts.test ? S_SUM : S_EMIT;
      end
      S_SUM: begin
        cmd.wrd     = !sts.win_done;
        cmd.acc_sum = 1'b1;
        if (sts.win_done && !sts.rd_vld) state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_MEAN;
      end
      S_MEAN: begin
        cmd.mean    = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt   = S_DEV;
      end
      S_DEV: begin
        cmd.wrd     = !sts.win_done;
        cmd.acc_dev = 1'b1;
        if (sts.win_done && !sts.rd_vld) state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.load_live = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  a_take_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but block did not go busy");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_hist && cmd.load_live))
    else $error("history and live loads at once");

endmodule

// ----- rtl/core/gtic_dp.sv -----
// Datapath: config registers, history and window stores, mean/deviation arithmetic, output register.
module gtic_dp #(
  parameter int HISTORY_DEPTH = gtic_pkg::HISTORY_DEPTH_DEF,
  parameter int WINDOW_LEN    = gtic_pkg::WINDOW_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [gtic_pkg::CFG_IW-1:0]          cfg_index,
  input  logic [gtic_pkg::CFG_DW-1:0]          cfg_wdata,
  input  logic signed [gtic_pkg::SAMPLE_W-1:0] in_accel_x,
  input  logic signed [gtic_pkg::SAMPLE_W-1:0] in_accel_y,
  input  logic signed [gtic_pkg::SAMPLE_W-1:0] in_accel_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [gtic_pkg::SAMPLE_W-1:0] out_sample_x,
  output logic signed [gtic_pkg::SAMPLE_W-1:0] out_sample_y,
  output logic signed [gtic_pkg::SAMPLE_W-1:0] out_sample_z,
  output logic                                 out_from_history,
  output logic                                 out_gesture_end,
  input  gtic_pkg::cmd_t                       cmd,
  output gtic_pkg::sts_t                       sts
);

  localparam int SW   = gtic_pkg::SAMPLE_W;
  localparam int ROWW = 3 * SW;
  localparam int HAW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HSW  = $clog2(2 * HISTORY_DEPTH + 1);
  localparam int WAW  = $clog2(WINDOW_LEN);
  localparam int CMAX = (HISTORY_DEPTH > WINDOW_LEN) ? HISTORY_DEPTH : WINDOW_LEN;
  localparam int CW   = $clog2(CMAX + 1);
  localparam int LW   = $clog2(WINDOW_LEN);
  localparam int AW   = SW + LW;           // magnitude of a window sum
  localparam int SUMW = AW + 1;
  localparam int K    = AW + 6;            // reciprocal shift, exact for all sums
  localparam int RCP  = ((1 << K) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int PW   = AW + K;
  localparam int MW   = SW + 1;
  localparam int DW   = SW + 2 + LW;

  // configuration
  logic [gtic_pkg::THR_W-1:0]  thr_r, idle_lim_r;
  logic [gtic_pkg::MINC_W-1:0] minc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= gtic_pkg::THR_RST;
      idle_lim_r <= gtic_pkg::IDLE_RST;
      minc_r     <= gtic_pkg::MINC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gtic_pkg::CFG_TRIG_THRESHOLD: thr_r      <= cfg_wdata[gtic_pkg::THR_W-1:0];
        gtic_pkg::CFG_IDLE_LIMIT:     idle_lim_r <= cfg_wdata[gtic_pkg::THR_W-1:0];
        gtic_pkg::CFG_MIN_CAPTURE:    minc_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sample capture and trigger
  logic signed [SW-1:0] smp_r [3];
  logic signed [SW-1:0] in_s  [3];
  logic [SW:0]          mag   [3];
  logic                 trig_now, trig_r, capt_r, idle_r;
  logic [15:0]          ci_r;

  assign in_s[0] = in_accel_x;
  assign in_s[1] = in_accel_y;
  assign in_s[2] = in_accel_z;

  always_comb begin
    trig_now = 1'b0;
    for (int a = 0; a < 3; a++) begin
      mag[a] = in_s[a][SW-1] ? (SW+1)'(-{in_s[a][SW-1], in_s[a]})
                             : (SW+1)'({in_s[a][SW-1], in_s[a]});
      if (mag[a] > (SW+1)'(thr_r)) trig_now = 1'b1;
    end
  end

  // history store: circular, valid bits read as zero when clear
  logic [ROWW-1:0]          hist_mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] hist_vld_r;
  logic [HAW-1:0]           hp_r, hp_inc;
  logic [ROWW-1:0]          hist_rd_r;
  logic [CW-1:0]            cnt_r;
  logic [HSW-1:0]           hsum;
  logic [HAW-1:0]           hraddr;
  logic                     hist_wr, hist_clr;

  assign hp_inc   = (hp_r == HAW'(HISTORY_DEPTH - 1)) ? '0 : hp_r + 1'b1;
  assign hist_wr  = cmd.take && !capt_r;
  assign hist_clr = cmd.load_live && idle_r;
  assign hsum     = HSW'(hp_r) + HSW'(1) + HSW'(cnt_r);
  assign hraddr   = (hsum >= HSW'(HISTORY_DEPTH)) ? HAW'(hsum - HSW'(HISTORY_DEPTH))
                                                  : HAW'(hsum);

  always_ff @(posedge clk) begin
    if (hist_wr) hist_mem[hp_inc] <= {in_accel_x, in_accel_y, in_accel_z};
    if (cmd.hrd) hist_rd_r <= hist_vld_r[hraddr] ? hist_mem[hraddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
      hp_r       <= '0;
    end else if (hist_clr) begin
      hist_vld_r <= '0;
    end else if (hist_wr) begin
      hist_vld_r[hp_inc] <= 1'b1;
      hp_r               <= hp_inc;
    end
  end

  // window store
  logic [ROWW-1:0] win_mem [WINDOW_LEN];
  logic [WAW-1:0]  wp_r;
  logic [ROWW-1:0] win_rd_r;
  logic            rd_vld_r, win_wr;

  assign win_wr = cmd.take && capt_r;

  always_ff @(posedge clk) begin
    if (win_wr) win_mem[wp_r] <= {in_accel_x, in_accel_y, in_accel_z};
    if (cmd.wrd) win_rd_r <= win_mem[cnt_r[WAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      rd_vld_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      rd_vld_r <= cmd.wrd;
      if (win_wr) wp_r <= (wp_r == WAW'(WINDOW_LEN - 1)) ? '0 : wp_r + 1'b1;
      if (cmd.cnt_clr) cnt_r <= '0;
      else if (cmd.hrd || cmd.wrd) cnt_r <= cnt_r + 1'b1;
    end
  end

  // per-axis mean and deviation lanes
  logic signed [SUMW-1:0] sum_r  [3];
  logic [PW-1:0]          prod_r [3];
  logic                   neg_r  [3];
  logic signed [MW-1:0]   mean_r [3];
  logic [DW-1:0]          dev_r  [3];
  logic signed [SW-1:0]   wv     [3];
  logic [AW-1:0]          asum   [3];
  logic [AW-1:0]          quo    [3];
  logic signed [SW+1:0]   diff   [3];
  logic [SW+1:0]          adiff  [3];
  logic [DW-1:0]          limit;
  logic                   all_below;

  assign limit = DW'(idle_lim_r) * DW'(WINDOW_LEN);

  always_comb begin
    all_below = 1'b1;
    for (int a = 0; a < 3; a++) begin
      wv[a]    = win_rd_r[ROWW-1-a*SW -: SW];
      asum[a]  = sum_r[a][SUMW-1] ? AW'(-sum_r[a]) : AW'(sum_r[a]);
      quo[a]   = AW'(prod_r[a] >> K);
      diff[a]  = (SW+2)'(wv[a]) - (SW+2)'(mean_r[a]);
      adiff[a] = diff[a][SW+1] ? (SW+2)'(-diff[a]) : (SW+2)'(diff[a]);
      if (!(dev_r[a] < limit)) all_below = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (cmd.cnt_clr) begin
        sum_r[a] <= '0;
        dev_r[a] <= '0;
      end else begin
        if (cmd.acc_sum && rd_vld_r) sum_r[a] <= sum_r[a] + SUMW'(wv[a]);
        if (cmd.acc_dev && rd_vld_r) dev_r[a] <= dev_r[a] + DW'(adiff[a]);
      end
      if (cmd.div) begin
        prod_r[a] <= PW'(asum[a]) * PW'(RCP);
        neg_r[a]  <= sum_r[a][SUMW-1];
      end
      // truncate toward zero: divide magnitude, restore sign
      if (cmd.mean) mean_r[a] <= neg_r[a] ? -MW'(quo[a]) : MW'(quo[a]);
    end
  end

  // capture control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capt_r <= 1'b0;
      ci_r   <= '0;
      trig_r <= 1'b0;
      idle_r <= 1'b0;
    end else begin
      if (cmd.take) begin
        trig_r <= trig_now;
        if (!capt_r && trig_now) begin
          capt_r <= 1'b1;
          ci_r   <= '0;
        end
      end
      if (cmd.chk) idle_r <= (ci_r >= minc_r) && (ci_r < 16'(WINDOW_LEN)) && (idle_lim_r != '0);
      if (cmd.cmp) idle_r <= all_below;
      if (cmd.load_live) begin
        if (idle_r) begin
          capt_r <= 1'b0;
          ci_r   <= '0;
        end else if (ci_r != 16'hFFFF) begin
          ci_r <= ci_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      smp_r[0] <= in_accel_x;
      smp_r[1] <= in_accel_y;
      smp_r[2] <= in_accel_z;
    end
  end

  // output register
  logic                 out_valid_r, from_hist_r, end_r;
  logic signed [SW-1:0] ox_r, oy_r, oz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load_hist || cmd.load_live) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hist) begin
      ox_r        <= hist_rd_r[ROWW-1 -: SW];
      oy_r        <= hist_rd_r[ROWW-1-SW -: SW];
      oz_r        <= hist_rd_r[SW-1:0];
      from_hist_r <= 1'b1;
      end_r       <= 1'b0;
    end else if (cmd.load_live) begin
      ox_r        <= smp_r[0];
      oy_r        <= smp_r[1];
      oz_r        <= smp_r[2];
      from_hist_r <= 1'b0;
      end_r       <= idle_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_x     = ox_r;
  assign out_sample_y     = oy_r;
  assign out_sample_z     = oz_r;
  assign out_from_history = from_hist_r;
  assign out_gesture_end  = end_r;

  assign sts.capturing = capt_r;
  assign sts.trig      = trig_r;
  assign sts.slot_free = !out_valid_r || !out_stall;
  assign sts.test      = (ci_r >= minc_r) && (ci_r >= 16'(WINDOW_LEN));
  assign sts.hist_done = (cnt_r == CW'(HISTORY_DEPTH));
  assign sts.win_done  = (cnt_r == CW'(WINDOW_LEN));
  assign sts.rd_vld    = rd_vld_r;

  a_hrd_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hrd |-> (cnt_r < CW'(HISTORY_DEPTH)))
    else $error("history read past depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_hist || cmd.load_live) |-> sts.slot_free)
    else $error("output register overwritten");

  a_end_fell: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(capt_r) |-> $past(cmd.load_live && idle_r))
    else $error("capture left without gesture end");

endmodule

// ----- rtl/core/gesture_trigger_idle_capture.sv -----
// Top level: threshold-triggered accelerometer capture with pre-trigger history and idle end.
//
//   channel | ports                              | direction
//   in      | in_valid/in_stall, in_accel_*      | request in
//   out     | out_valid/out_stall, out_sample_*  | request out
//   cfg     | cfg_we, cfg_index, cfg_wdata       | register write
//
// One request at a time. Observing: on a trigger, a read setup step, then the history
// entries in turn, each loaded when the output is not stalled, paced by the single
// history read port. Capturing: the idle test, when it runs, makes two passes over the
// window store. Reset is synchronous; a stalled output holds the block in its load step.
module gesture_trigger_idle_capture #(
  parameter int HISTORY_DEPTH = gtic_pkg::HISTORY_DEPTH_DEF,
  parameter int WINDOW_LEN    = gtic_pkg::WINDOW_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [gtic_pkg::CFG_IW-1:0]          cfg_index,
  input  logic [gtic_pkg::CFG_DW-1:0]          cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [gtic_pkg::SAMPLE_W-1:0] in_accel_x,
  input  logic signed [gtic_pkg::SAMPLE_W-1:0] in_accel_y,
  input  logic signed [gtic_pkg::SAMPLE_W-1:0] in_accel_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [gtic_pkg::SAMPLE_W-1:0] out_sample_x,
  output logic signed [gtic_pkg::SAMPLE_W-1:0] out_sample_y,
  output logic signed [gtic_pkg::SAMPLE_W-1:0] out_sample_z,
  output logic                                 out_from_history,
  output logic                                 out_gesture_end
);

  gtic_pkg::cmd_t cmd;
  gtic_pkg::sts_t sts;

  gtic_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gtic_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .WINDOW_LEN    (WINDOW_LEN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_accel_x       (in_accel_x),
    .in_accel_y       (in_accel_y),
    .in_accel_z       (in_accel_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_x     (out_sample_x),
    .out_sample_y     (out_sample_y),
    .out_sample_z     (out_sample_z),
    .out_from_history (out_from_history),
    .out_gesture_end  (out_gesture_end),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
